>>> rtl/core/tdq_pkg.sv
// Shared types, codes and constants of the task dispatch queue.
// Used by tdq_ctrl, tdq_dpath and task_dispatch_queue_top; depends on nothing.
package tdq_pkg;

	localparam int QueueDepthDefault = 64;
	localparam int PoolCountDefault  = 4;

	localparam int HandleW = 16;
	localparam int PoolW   = 2;
	localparam int CfgW    = 24;
	localparam int LimitW  = 6;
	localparam int PendW   = 8;
	localparam int RunW    = 7;
	localparam int DoneW   = 32;
	localparam int RemW    = 7;

	localparam logic [RunW-1:0]  RunMax  = 7'd127;
	localparam logic [PendW-1:0] PendMax = 8'd255;

	// Command codes.
	localparam logic [2:0] CMD_PUSH     = 3'd0;
	localparam logic [2:0] CMD_WPOP     = 3'd1;
	localparam logic [2:0] CMD_PPOP     = 3'd2;
	localparam logic [2:0] CMD_COMPLETE = 3'd3;
	localparam logic [2:0] CMD_CLEAR    = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_COUNT = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_POOL_LIMITS = 2'd0;
	localparam logic [1:0] CFG_BG_POOLS    = 2'd1;
	localparam logic [1:0] CFG_BG_ONLY     = 2'd2;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [PoolW-1:0]   pool_id;
		logic               high_priority;
		logic [HandleW-1:0] task_handle;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [HandleW-1:0] popped_handle;
		logic [PoolW-1:0]   popped_pool;
		logic               pool_idle;
		logic [RemW-1:0]    removed_count;
		logic [DoneW-1:0]   pool_done;
	} out_item_t;

	typedef struct packed {
		logic [PoolW-1:0]   pool;
		logic [HandleW-1:0] handle;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic       push_tail;
		logic       set_top;
		logic       shift_up;
		logic       head_wr;
		logic       scan_start;
		logic       scan_next;
		logic       take;
		logic       clr_start;
		logic       cmp_step;
		logic       cmp_end;
		logic       complete;
		logic       load_res;
		logic [1:0] res_status;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] cmd;
		logic       pid_ok;
		logic       high_priority;
		logic       full;
		logic       len_zero;
		logic       rp_zero;
		logic       rp_end;
		logic       elig;
		logic       pool_room;
		logic       pend_zero;
		logic       out_busy;
	} dp_sts_t;

endpackage

>>> rtl/core/tdq_dpath.sv
// Datapath of the task dispatch queue: entry memory, pointers, pool counters,
// configuration registers and the result register. Depends on tdq_pkg.
module tdq_dpath import tdq_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDefault,
	parameter int POOL_COUNT  = PoolCountDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  in_item_t            in_item,
	output out_item_t           out_item,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CfgW-1:0]     cfg_data,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	function automatic logic has_room(logic [RunW-1:0] run, logic [LimitW-1:0] lim);
		logic r;
		r = (run < RunMax) && ((lim == '0) || ({1'b0, run} < {2'b00, lim}));
		return r;
	endfunction

	logic [CfgW-1:0]    limits_q;
	logic [3:0]         bg_pools_q;
	logic               bg_only_q;

	in_item_t           item_q;
	entry_t             mem [QUEUE_DEPTH];
	entry_t             rdata_q;
	logic [LW-1:0]      len_q, rp_q, wp_q;
	logic [PendW-1:0]   pend_q [POOL_COUNT];
	logic [RunW-1:0]    run_q  [POOL_COUNT];
	logic [DoneW-1:0]   done_q [POOL_COUNT];
	logic [HandleW-1:0] found_handle_q;
	logic [PoolW-1:0]   found_pool_q;
	logic               idle_q;
	logic [RemW-1:0]    rem_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	entry_t             mem_wd;
	logic               pid_ok, ent_ok, is_clear, keep, settle;
	logic [LW-1:0]      dn, rp_inc;
	logic [15:0]        pend_x, run_x, dn_x;
	logic [PendW-1:0]   pend_new;
	logic [RunW-1:0]    run_new;

	assign pid_ok   = {1'b0, item_q.pool_id} < 3'(POOL_COUNT);
	assign ent_ok   = {1'b0, rdata_q.pool} < 3'(POOL_COUNT);
	assign is_clear = item_q.cmd == CMD_CLEAR;
	assign keep     = !is_clear || (rdata_q.pool != item_q.pool_id);
	assign rp_inc   = rp_q + LW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q   <= '0;
			bg_pools_q <= '0;
			bg_only_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POOL_LIMITS: limits_q   <= cfg_data;
				CFG_BG_POOLS:    bg_pools_q <= cfg_data[3:0];
				CFG_BG_ONLY:     bg_only_q  <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// Memory write port.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = rdata_q;
		if (cmd.push_tail) begin
			mem_we = 1'b1;
			mem_wa = len_q[AW-1:0];
			mem_wd = '{pool: item_q.pool_id, handle: item_q.task_handle};
		end else if (cmd.head_wr) begin
			mem_we = 1'b1;
			mem_wd = '{pool: item_q.pool_id, handle: item_q.task_handle};
		end else if (cmd.shift_up) begin
			mem_we = 1'b1;
			mem_wa = rp_inc[AW-1:0];
		end else if (cmd.cmp_step && keep) begin
			mem_we = 1'b1;
			mem_wa = wp_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[rp_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_item;
		end
	end

	// Settling a clear or a complete: lower pending and running, raise done.
	assign settle   = cmd.complete || (cmd.cmp_end && is_clear);
	assign dn       = cmd.complete ? LW'(1) : (len_q - wp_q);
	assign dn_x     = 16'(dn);
	assign pend_x   = 16'(pend_q[item_q.pool_id]);
	assign run_x    = 16'(run_q[item_q.pool_id]);
	assign pend_new = (pend_x > dn_x) ? PendW'(pend_x - dn_x) : '0;
	assign run_new  = (run_x > dn_x) ? RunW'(run_x - dn_x) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			rp_q  <= '0;
			wp_q  <= '0;
			for (int k = 0; k < POOL_COUNT; k++) begin
				pend_q[k] <= '0;
				run_q[k]  <= '0;
				done_q[k] <= '0;
			end
			found_handle_q <= '0;
			found_pool_q   <= '0;
			idle_q         <= 1'b0;
			rem_q          <= '0;
		end else begin
			if (cmd.accept) begin
				found_handle_q <= '0;
				found_pool_q   <= '0;
				idle_q         <= 1'b0;
				rem_q          <= '0;
			end
			if (cmd.push_tail || cmd.head_wr) begin
				len_q <= len_q + LW'(1);
				if (pend_q[item_q.pool_id] != PendMax) begin
					pend_q[item_q.pool_id] <= pend_q[item_q.pool_id] + PendW'(1);
				end
			end
			if (cmd.set_top) begin
				rp_q <= len_q - LW'(1);
			end
			if (cmd.shift_up) begin
				rp_q <= rp_q - LW'(1);
			end
			if (cmd.scan_start) begin
				rp_q <= '0;
			end
			if (cmd.scan_next) begin
				rp_q <= rp_inc;
			end
			if (cmd.take) begin
				found_handle_q     <= rdata_q.handle;
				found_pool_q       <= rdata_q.pool;
				run_q[rdata_q.pool] <= run_q[rdata_q.pool] + RunW'(1);
				wp_q <= rp_q;
				rp_q <= rp_inc;
			end
			if (cmd.clr_start) begin
				rp_q <= '0;
				wp_q <= '0;
			end
			if (cmd.cmp_step) begin
				rp_q <= rp_inc;
				if (keep) begin
					wp_q <= wp_q + LW'(1);
				end
			end
			if (cmd.cmp_end) begin
				len_q <= wp_q;
			end
			if (settle) begin
				pend_q[item_q.pool_id] <= pend_new;
				run_q[item_q.pool_id]  <= run_new;
				done_q[item_q.pool_id] <= done_q[item_q.pool_id] + DoneW'(dn);
				idle_q                 <= pend_new == '0;
				if (cmd.cmp_end) begin
					rem_q <= (dn > LW'(127)) ? RemW'(127) : RemW'(dn);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			out_q.status        <= cmd.res_status;
			out_q.popped_handle <= found_handle_q;
			out_q.popped_pool   <= found_pool_q;
			out_q.pool_idle     <= idle_q;
			out_q.removed_count <= rem_q;
			out_q.pool_done     <= pid_ok ? done_q[item_q.pool_id] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		sts.cmd           = item_q.cmd;
		sts.pid_ok        = pid_ok;
		sts.high_priority = item_q.high_priority;
		sts.full          = len_q == LW'(QUEUE_DEPTH);
		sts.len_zero      = len_q == '0;
		sts.rp_zero       = rp_q == '0;
		sts.rp_end        = rp_q == len_q;
		sts.pool_room     = pid_ok && has_room(run_q[item_q.pool_id],
			limits_q[LimitW*item_q.pool_id +: LimitW]);
		if (item_q.cmd == CMD_PPOP) begin
			sts.elig = ent_ok && (rdata_q.pool == item_q.pool_id);
		end else begin
			sts.elig = ent_ok && (!bg_only_q || bg_pools_q[rdata_q.pool]) &&
				has_room(run_q[rdata_q.pool], limits_q[LimitW*rdata_q.pool +: LimitW]);
		end
		sts.pend_zero     = pend_q[item_q.pool_id] == '0;
		sts.out_busy      = out_valid_q && !out_ready;
	end

`ifndef SYNTH
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(QUEUE_DEPTH))
		else $error("queue length beyond depth");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |-> !(out_valid_q && !out_ready))
		else $error("result loaded over a waiting item");
	a_push_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_tail |=> len_q == $past(len_q) + LW'(1))
		else $error("tail push did not grow the queue");
`endif

endmodule

>>> rtl/core/tdq_ctrl.sv
// Controller of the task dispatch queue: sequences pushes, scans, compaction
// sweeps and result hand-off. Depends on tdq_pkg.
module tdq_ctrl import tdq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_SU_RD    = 4'd2;
	localparam logic [3:0] S_SU_WR    = 4'd3;
	localparam logic [3:0] S_HEAD_WR  = 4'd4;
	localparam logic [3:0] S_SCAN_RD  = 4'd5;
	localparam logic [3:0] S_SCAN_EV  = 4'd6;
	localparam logic [3:0] S_CMP_RD   = 4'd7;
	localparam logic [3:0] S_CMP_WR   = 4'd8;
	localparam logic [3:0] S_FINISH   = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] res_q, res_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		cmd            = '0;
		cmd.res_status = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				res_d   = ST_OK;
				if (sts.cmd > CMD_CLEAR) begin
					res_d = ST_NONE;
				end else if (!sts.pid_ok) begin
					res_d = ST_COUNT;
				end else begin
					unique case (sts.cmd)
						CMD_PUSH: begin
							if (sts.full) begin
								res_d = ST_FULL;
							end else if (!sts.high_priority) begin
								cmd.push_tail = 1'b1;
							end else if (sts.len_zero) begin
								state_d = S_HEAD_WR;
							end else begin
								cmd.set_top = 1'b1;
								state_d     = S_SU_RD;
							end
						end
						CMD_WPOP, CMD_PPOP: begin
							if (sts.cmd == CMD_PPOP && !sts.pool_room) begin
								res_d = ST_NONE;
							end else begin
								cmd.scan_start = 1'b1;
								state_d        = S_SCAN_RD;
							end
						end
						CMD_COMPLETE: begin
							if (sts.pend_zero) begin
								res_d = ST_COUNT;
							end else begin
								cmd.complete = 1'b1;
							end
						end
						default: begin
							cmd.clr_start = 1'b1;
							state_d       = S_CMP_RD;
						end
					endcase
				end
			end
			S_SU_RD: state_d = S_SU_WR;
			S_SU_WR: begin
				cmd.shift_up = 1'b1;
				state_d      = sts.rp_zero ? S_HEAD_WR : S_SU_RD;
			end
			S_HEAD_WR: begin
				cmd.head_wr = 1'b1;
				res_d       = ST_OK;
				state_d     = S_FINISH;
			end
			S_SCAN_RD: begin
				if (sts.rp_end) begin
					res_d   = ST_NONE;
					state_d = S_FINISH;
				end else begin
					state_d = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				if (sts.elig) begin
					cmd.take = 1'b1;
					res_d    = ST_OK;
					state_d  = S_CMP_RD;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_CMP_RD: begin
				if (sts.rp_end) begin
					cmd.cmp_end = 1'b1;
					state_d     = S_FINISH;
				end else begin
					state_d = S_CMP_WR;
				end
			end
			S_CMP_WR: begin
				cmd.cmp_step = 1'b1;
				state_d      = S_CMP_RD;
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

endmodule

>>> rtl/core/task_dispatch_queue_top.sv
// Top level of the task dispatch queue: controller and datapath.
// Depends on tdq_pkg, tdq_ctrl and tdq_dpath.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   in_item  (in_item_t)
//   output   out_valid / out_ready out_item (out_item_t)
//   config   cfg_we                cfg_index, cfg_data
//
// One item at a time. A tail push, a complete or a refused command goes from
// dispatch straight to the finish state, which loads the result register; a
// high-priority push, a pop and a clear step through the queued entries one by
// one, set by the single read and write port of the entry memory.
// The queue memory needs no clearing pass after reset.
// A result waiting on out_ready does not stop the next item being accepted and
// worked on, but that item holds its result, with in_ready low, until the
// output register frees.
module task_dispatch_queue_top import tdq_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDefault,
	parameter int POOL_COUNT  = PoolCountDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_item,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [CfgW-1:0] cfg_data
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	tdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.POOL_COUNT  (POOL_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
